/* hdl/fpd_pkg.sv */
// Shared types and constants for the signed fixed-point divider.
// No dependencies; used by every module of the block.
package fpd_pkg;

    localparam int FPD_WORD_WIDTH    = 32;
    localparam int FPD_FRACTION_BITS = 16;

    // Control that rides alongside each item down the cell chain
    typedef struct packed {
        logic valid;
        logic negate;
        logic div_zero;
        logic high;     // a quotient bit at or above WORD_WIDTH has been set
    } fpd_ctrl_t;

endpackage

/* hdl/fpd_prep.sv */
// Operand stage: magnitudes, result sign and zero-divisor detection, registered.
// Depends on fpd_pkg.
module fpd_prep #(
    parameter int WORD_WIDTH = fpd_pkg::FPD_WORD_WIDTH
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         en,
    input  logic                         in_valid,
    input  logic signed [WORD_WIDTH-1:0] dividend,
    input  logic signed [WORD_WIDTH-1:0] divisor,
    output fpd_pkg::fpd_ctrl_t           ctrl_out,
    output logic        [WORD_WIDTH-1:0] num_out,
    output logic        [WORD_WIDTH-1:0] den_out
);
    import fpd_pkg::*;

    fpd_ctrl_t             ctrl_reg, ctrl_next;
    logic [WORD_WIDTH-1:0] num_reg, num_next;
    logic [WORD_WIDTH-1:0] den_reg, den_next;

    // most negative value maps to 2^(W-1), which fits unsigned
    always_comb begin
        num_next = dividend[WORD_WIDTH-1] ? (~$unsigned(dividend) + 1'b1)
                                          : $unsigned(dividend);
        den_next = divisor[WORD_WIDTH-1] ? (~$unsigned(divisor) + 1'b1)
                                         : $unsigned(divisor);
        ctrl_next.valid    = in_valid;
        ctrl_next.negate   = dividend[WORD_WIDTH-1] ^ divisor[WORD_WIDTH-1];
        ctrl_next.div_zero = (divisor == '0);
        ctrl_next.high     = 1'b0;
    end

    // only the valid bit is reset; the payload follows it
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ctrl_reg.valid <= 1'b0;
        end else if (en) begin
            ctrl_reg.valid <= ctrl_next.valid;
        end
        if (en) begin
            ctrl_reg.negate   <= ctrl_next.negate;
            ctrl_reg.div_zero <= ctrl_next.div_zero;
            ctrl_reg.high     <= ctrl_next.high;
            num_reg           <= num_next;
            den_reg           <= den_next;
        end
    end

    assign ctrl_out = ctrl_reg;
    assign num_out  = num_reg;
    assign den_out  = den_reg;

endmodule

/* hdl/fpd_cell.sv */
// One restoring-division cell: brings in one numerator bit, resolves one quotient bit.
// Depends on fpd_pkg.
module fpd_cell #(
    parameter int WORD_WIDTH = fpd_pkg::FPD_WORD_WIDTH
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  en,
    input  fpd_pkg::fpd_ctrl_t    ctrl_in,
    input  logic [WORD_WIDTH-1:0] num_in,
    input  logic [WORD_WIDTH-1:0] den_in,
    input  logic [WORD_WIDTH-1:0] rem_in,
    input  logic [WORD_WIDTH-1:0] quo_in,
    output fpd_pkg::fpd_ctrl_t    ctrl_out,
    output logic [WORD_WIDTH-1:0] num_out,
    output logic [WORD_WIDTH-1:0] den_out,
    output logic [WORD_WIDTH-1:0] rem_out,
    output logic [WORD_WIDTH-1:0] quo_out
);
    import fpd_pkg::*;

    fpd_ctrl_t             ctrl_reg, ctrl_next;
    logic [WORD_WIDTH-1:0] num_reg, num_next;
    logic [WORD_WIDTH-1:0] den_reg;
    logic [WORD_WIDTH-1:0] rem_reg, rem_next;
    logic [WORD_WIDTH-1:0] quo_reg, quo_next;
    logic [WORD_WIDTH:0]   trial;
    logic [WORD_WIDTH+1:0] diff;
    logic                  qbit;

    // remainder stays below the divisor (at most 2^(W-1)), so W bits hold it
    always_comb begin
        trial     = {rem_in, num_in[WORD_WIDTH-1]};
        diff      = {1'b0, trial} - {2'b00, den_in};
        qbit      = ~diff[WORD_WIDTH+1];
        rem_next  = qbit ? diff[WORD_WIDTH-1:0] : trial[WORD_WIDTH-1:0];
        quo_next  = {quo_in[WORD_WIDTH-2:0], qbit};
        num_next  = {num_in[WORD_WIDTH-2:0], 1'b0};
        ctrl_next = ctrl_in;
        ctrl_next.high = ctrl_in.high | quo_in[WORD_WIDTH-1];
    end

    // only the valid bit is reset; the payload follows it
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ctrl_reg.valid <= 1'b0;
        end else if (en) begin
            ctrl_reg.valid <= ctrl_next.valid;
        end
        if (en) begin
            ctrl_reg.negate   <= ctrl_next.negate;
            ctrl_reg.div_zero <= ctrl_next.div_zero;
            ctrl_reg.high     <= ctrl_next.high;
            num_reg           <= num_next;
            den_reg           <= den_in;
            rem_reg           <= rem_next;
            quo_reg           <= quo_next;
        end
    end

    assign ctrl_out = ctrl_reg;
    assign num_out  = num_reg;
    assign den_out  = den_reg;
    assign rem_out  = rem_reg;
    assign quo_out  = quo_reg;

endmodule

/* hdl/fpd_outbuf.sv */
// Output register with a skid entry, so the chain keeps moving while a result waits.
// Depends on fpd_pkg for its default DATA_WIDTH only.
module fpd_outbuf #(
    parameter int DATA_WIDTH = fpd_pkg::FPD_WORD_WIDTH + 2
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic [DATA_WIDTH-1:0] in_data,
    output logic                  m_valid,
    input  logic                  m_ready,
    output logic [DATA_WIDTH-1:0] m_data
);
    logic                  out_valid_reg;
    logic                  skid_valid_reg;
    logic [DATA_WIDTH-1:0] out_data_reg;
    logic [DATA_WIDTH-1:0] skid_data_reg;
    logic                  in_xfer;

    assign in_ready = ~skid_valid_reg;
    assign in_xfer  = in_valid & in_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (skid_valid_reg) begin
            if (m_ready) begin
                skid_valid_reg <= 1'b0;
            end
        end else if (in_xfer) begin
            if (out_valid_reg && !m_ready) begin
                skid_valid_reg <= 1'b1;
            end else begin
                out_valid_reg <= 1'b1;
            end
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (skid_valid_reg) begin
            if (m_ready) begin
                out_data_reg <= skid_data_reg;
            end
        end else if (in_xfer) begin
            if (out_valid_reg && !m_ready) begin
                skid_data_reg <= in_data;
            end else begin
                out_data_reg <= in_data;
            end
        end
    end

    assign m_valid = out_valid_reg;
    assign m_data  = out_data_reg;

endmodule

/* hdl/fixed_point_divider_q16_16_top.sv */
// Top level of the signed Q16.16 fixed-point divider: operand stage, cell chain, output buffer.
// Depends on fpd_pkg, fpd_prep, fpd_cell, fpd_outbuf.
//
//  channel | direction | handshake          | payload
//  s_      | in        | s_valid / s_ready  | s_dividend, s_divisor
//  m_      | out       | m_valid / m_ready  | m_quotient, m_divide_by_zero, m_overflow
//
// One transfer in per cycle, sustained while the m_ side takes results. The path runs through
// one operand stage, one cell per quotient bit and one output register.
// Reset (aresetn low, synchronous) empties the chain and the output buffer.
// A stalled m_ side fills the output register and then its skid entry; only then
// does the whole chain hold and s_ready drop.
module fixed_point_divider_q16_16_top #(
    parameter int WORD_WIDTH    = fpd_pkg::FPD_WORD_WIDTH,
    parameter int FRACTION_BITS = fpd_pkg::FPD_FRACTION_BITS
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_valid,
    output logic                         s_ready,
    input  logic signed [WORD_WIDTH-1:0] s_dividend,
    input  logic signed [WORD_WIDTH-1:0] s_divisor,
    output logic                         m_valid,
    input  logic                         m_ready,
    output logic signed [WORD_WIDTH-1:0] m_quotient,
    output logic                         m_divide_by_zero,
    output logic                         m_overflow
);
    import fpd_pkg::*;

    localparam int NCELLS = WORD_WIDTH + FRACTION_BITS;

    fpd_ctrl_t             ctrl [0:NCELLS];
    logic [WORD_WIDTH-1:0] num  [0:NCELLS];
    logic [WORD_WIDTH-1:0] den  [0:NCELLS];
    logic [WORD_WIDTH-1:0] rem  [0:NCELLS];
    logic [WORD_WIDTH-1:0] quo  [0:NCELLS];

    logic                  pipe_en;
    logic [WORD_WIDTH-1:0] q_fin;
    logic [WORD_WIDTH-1:0] q_res;
    logic                  at_least_half;
    logic                  above_half;
    logic                  ovf;
    logic [WORD_WIDTH+1:0] res_data;
    logic [WORD_WIDTH+1:0] m_data;

    assign s_ready = pipe_en;

    fpd_prep #(.WORD_WIDTH(WORD_WIDTH)) u_prep (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .en       (pipe_en),
        .in_valid (s_valid),
        .dividend (s_dividend),
        .divisor  (s_divisor),
        .ctrl_out (ctrl[0]),
        .num_out  (num[0]),
        .den_out  (den[0])
    );

    assign rem[0] = '0;
    assign quo[0] = '0;

    for (genvar i = 0; i < NCELLS; i++) begin : g_cell
        fpd_cell #(.WORD_WIDTH(WORD_WIDTH)) u_cell (
            .aclk     (aclk),
            .aresetn  (aresetn),
            .en       (pipe_en),
            .ctrl_in  (ctrl[i]),
            .num_in   (num[i]),
            .den_in   (den[i]),
            .rem_in   (rem[i]),
            .quo_in   (quo[i]),
            .ctrl_out (ctrl[i+1]),
            .num_out  (num[i+1]),
            .den_out  (den[i+1]),
            .rem_out  (rem[i+1]),
            .quo_out  (quo[i+1])
        );
    end

    // Full quotient vs 2^(W-1): a negative result may reach it exactly, a positive one not
    always_comb begin
        q_fin         = quo[NCELLS];
        at_least_half = ctrl[NCELLS].high | q_fin[WORD_WIDTH-1];
        above_half    = ctrl[NCELLS].high
                      | (q_fin[WORD_WIDTH-1] & (|q_fin[WORD_WIDTH-2:0]));
        if (ctrl[NCELLS].div_zero) begin
            q_res = '0;
            ovf   = 1'b0;
        end else if (ctrl[NCELLS].negate) begin
            q_res = ~q_fin + 1'b1;
            ovf   = above_half;
        end else begin
            q_res = q_fin;
            ovf   = at_least_half;
        end
        res_data = {q_res, ctrl[NCELLS].div_zero, ovf};
    end

    fpd_outbuf #(.DATA_WIDTH(WORD_WIDTH + 2)) u_outbuf (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (ctrl[NCELLS].valid),
        .in_ready (pipe_en),
        .in_data  (res_data),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_data   (m_data)
    );

    assign m_quotient       = $signed(m_data[WORD_WIDTH+1:2]);
    assign m_divide_by_zero = m_data[1];
    assign m_overflow       = m_data[0];

endmodule

/* hdl/fpd_checker.sv */
// Port-level checks for the fixed-point divider, bound to the top level.
// Depends on fixed_point_divider_q16_16_top and fpd_pkg.
module fpd_checker #(
    parameter int WORD_WIDTH = fpd_pkg::FPD_WORD_WIDTH
) (
    input logic                         aclk,
    input logic                         aresetn,
    input logic                         s_valid,
    input logic                         s_ready,
    input logic signed [WORD_WIDTH-1:0] s_dividend,
    input logic signed [WORD_WIDTH-1:0] s_divisor,
    input logic                         m_valid,
    input logic                         m_ready,
    input logic signed [WORD_WIDTH-1:0] m_quotient,
    input logic                         m_divide_by_zero,
    input logic                         m_overflow
);

    // a waiting operand pair keeps its value until the transfer
    a_s_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && !s_ready |=> s_valid && $stable(s_dividend) && $stable(s_divisor))
        else $error("operands changed while stalled");

    // a held result keeps its value until the transfer
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_quotient)
            && $stable(m_divide_by_zero) && $stable(m_overflow))
        else $error("result changed while stalled");

    // zero divisor gives a clean zero, never overflow
    a_dz: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_divide_by_zero |-> m_quotient == '0 && !m_overflow)
        else $error("divide by zero result malformed");

    // input only backs off when a result is already waiting
    a_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> m_valid)
        else $error("s_ready low with nothing to deliver");

    // nothing comes out of an emptied block
    a_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_valid && s_ready)
        else $error("output not cleared by reset");

endmodule

bind fixed_point_divider_q16_16_top fpd_checker #(.WORD_WIDTH(WORD_WIDTH)) u_fpd_checker (
    .aclk             (aclk),
    .aresetn          (aresetn),
    .s_valid          (s_valid),
    .s_ready          (s_ready),
    .s_dividend       (s_dividend),
    .s_divisor        (s_divisor),
    .m_valid          (m_valid),
    .m_ready          (m_ready),
    .m_quotient       (m_quotient),
    .m_divide_by_zero (m_divide_by_zero),
    .m_overflow       (m_overflow)
);

/* tb/fixed_point_divider_q16_16_top_tb.sv */
// Self-checking bench for the signed Q16.16 divider: directed corners, then random operands.
// Depends on fpd_pkg and fixed_point_divider_q16_16_top; both channels idle and stall at random.
`timescale 1ns / 1ps

module fixed_point_divider_q16_16_top_tb;
    import fpd_pkg::*;

    localparam int WW = FPD_WORD_WIDTH;
    localparam int FB = FPD_FRACTION_BITS;
    localparam int RANDOM_OPERANDS = 1900;
    localparam int DRAIN_CYCLES = WW + FB + 12;

    typedef logic [WW+FB:0] wide_t;
    localparam wide_t SIGN_WEIGHT = wide_t'(1) << (WW - 1);

    typedef struct {
        logic signed [WW-1:0] dividend;
        logic signed [WW-1:0] divisor;
    } div_operands_t;

    typedef struct {
        logic signed [WW-1:0] quotient;
        logic                 divide_by_zero;
        logic                 overflow;
    } quotient_result_t;

    logic                 aclk = 1'b0;
    logic                 aresetn = 1'b0;
    logic                 s_valid = 1'b0;
    logic                 s_ready;
    logic signed [WW-1:0] s_dividend = '0;
    logic signed [WW-1:0] s_divisor = '0;
    logic                 m_valid;
    logic                 m_ready = 1'b0;
    logic signed [WW-1:0] m_quotient;
    logic                 m_divide_by_zero;
    logic                 m_overflow;

    div_operands_t    pending_operands[$];
    quotient_result_t expected_quotients[$];
    int unsigned      operands_total = 0;
    int unsigned      transfers_in = 0;
    int unsigned      mismatches = 0;
    int unsigned      send_gap = 0;
    int unsigned      send_calm = 0;
    int unsigned      recv_stall = 0;
    int unsigned      recv_calm = 0;

    fixed_point_divider_q16_16_top dut (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_dividend       (s_dividend),
        .s_divisor        (s_divisor),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_quotient       (m_quotient),
        .m_divide_by_zero (m_divide_by_zero),
        .m_overflow       (m_overflow)
    );

    always #5 aclk = ~aclk;

    // floor(|a| * 2^FB / |b|), negated on differing signs; the wide quotient decides overflow
    function automatic quotient_result_t divide_q16_16(div_operands_t op);
        quotient_result_t res;
        wide_t            mag_a;
        wide_t            mag_b;
        wide_t            full;
        logic             negate;
        res.quotient       = '0;
        res.divide_by_zero = 1'b0;
        res.overflow       = 1'b0;
        if (op.divisor == '0) begin
            res.divide_by_zero = 1'b1;
            return res;
        end
        mag_a  = wide_t'(op.dividend);
        mag_b  = wide_t'(op.divisor);
        mag_a  = op.dividend[WW-1] ? -mag_a : mag_a;
        mag_b  = op.divisor[WW-1] ? -mag_b : mag_b;
        negate = op.dividend[WW-1] ^ op.divisor[WW-1];
        full   = (mag_a << FB) / mag_b;
        if (negate) begin
            res.quotient = -full[WW-1:0];
            res.overflow = full > SIGN_WEIGHT;
        end else begin
            res.quotient = full[WW-1:0];
            res.overflow = full >= SIGN_WEIGHT;
        end
        return res;
    endfunction

    function automatic int unsigned pick_idle_length();
        int unsigned r;
        r = $urandom_range(99);
        if (r < 65)
            return 0;
        else if (r < 93)
            return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    function automatic logic signed [WW-1:0] with_random_sign(logic signed [WW-1:0] v);
        return $urandom_range(1) ? -v : v;
    endfunction

    task automatic report_mismatch(string what, logic [WW-1:0] want, logic [WW-1:0] got);
        mismatches++;
        $display("%0t: mismatch on %s: expected %h, got %h", $realtime, what, want, got);
    endtask

    task automatic queue_operands(logic [WW-1:0] a, logic [WW-1:0] b);
        div_operands_t op;
        op.dividend = a;
        op.divisor  = b;
        pending_operands.push_back(op);
        operands_total++;
    endtask

    // Driver: holds the payload until the transfer, then optionally idles before the next one
    always @(posedge aclk) begin
        div_operands_t op;
        logic          holding;
        if (!aresetn) begin
            s_valid    <= 1'b0;
            s_dividend <= '0;
            s_divisor  <= '0;
        end else begin
            holding = s_valid && !s_ready;
            if (s_valid && s_ready) begin
                op.dividend = s_dividend;
                op.divisor  = s_divisor;
                expected_quotients.push_back(divide_q16_16(op));
                transfers_in++;
            end
            if (!holding) begin
                if (send_gap > 0) begin
                    send_gap--;
                    s_valid <= 1'b0;
                end else if (pending_operands.size() > 0) begin
                    op = pending_operands.pop_front();
                    s_dividend <= op.dividend;
                    s_divisor  <= op.divisor;
                    s_valid    <= 1'b1;
                    if (send_calm > 0)
                        send_calm--;
                    else if ($urandom_range(99) == 0)
                        send_calm = $urandom_range(40, 120);
                    else
                        send_gap = pick_idle_length();
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // Monitor: checks each result transfer against the oldest expectation
    always @(posedge aclk) begin
        quotient_result_t want;
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                if (expected_quotients.size() == 0) begin
                    report_mismatch("unexpected result, quotient", '0, m_quotient);
                end else begin
                    want = expected_quotients.pop_front();
                    if (m_quotient !== want.quotient)
                        report_mismatch("quotient", want.quotient, m_quotient);
                    if (m_divide_by_zero !== want.divide_by_zero)
                        report_mismatch("divide_by_zero", WW'(want.divide_by_zero),
                                        WW'(m_divide_by_zero));
                    if (m_overflow !== want.overflow)
                        report_mismatch("overflow", WW'(want.overflow), WW'(m_overflow));
                end
            end
            if (recv_stall > 0) begin
                recv_stall--;
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
                if (recv_calm > 0)
                    recv_calm--;
                else if ($urandom_range(99) == 0)
                    recv_calm = $urandom_range(40, 120);
                else
                    recv_stall = pick_idle_length();
            end
        end
    end

    initial begin
        #8_000_000;
        $display("== FAIL ==");
        $finish;
    end

    initial begin
        logic signed [WW-1:0] corners[10];
        logic signed [WW-1:0] a;
        logic signed [WW-1:0] b;
        int unsigned          r;

        corners = '{32'h8000_0000, 32'h7FFF_FFFF, 32'h0000_0001, 32'hFFFF_FFFF,
                    32'h0001_0000, 32'hFFFF_0000, 32'h0000_8000, 32'h8000_0001,
                    32'h7FFF_0000, 32'h0000_0000};

        // directed corners
        queue_operands(32'h0001_0000, 32'h0000_0000);   // zero divisor
        queue_operands(32'h8000_0000, 32'h0000_0000);
        queue_operands(32'h0000_0000, 32'h0000_0000);
        queue_operands(32'h0000_0000, 32'hFFFF_0000);   // zero dividend, signs differ
        queue_operands(32'h8000_0000, 32'h8000_0000);
        queue_operands(32'h8000_0000, 32'h0001_0000);   // exactly most negative
        queue_operands(32'h8000_0000, 32'hFFFF_0000);   // +2^31 does not fit
        queue_operands(32'h7FFF_FFFF, 32'h7FFF_FFFF);
        queue_operands(32'h7FFF_FFFF, 32'h0000_0001);   // wrapped overflow
        queue_operands(32'h0000_0001, 32'h7FFF_FFFF);
        queue_operands(32'h0001_0000, 32'h0003_0000);
        queue_operands(32'hFFFF_0000, 32'h0003_0000);
        queue_operands(32'h0001_0000, 32'hFFFD_0000);
        queue_operands(32'hFFFF_0000, 32'hFFFD_0000);
        queue_operands(32'h7FFF_FFFF, 32'h8000_0000);
        queue_operands(32'h8000_0000, 32'h7FFF_FFFF);
        queue_operands(32'h4000_0000, 32'h0000_8000);
        queue_operands(32'hC000_0000, 32'h0000_8000);
        queue_operands(32'h8000_0000, 32'hFFFF_FFFF);
        queue_operands(32'hFFFF_FFFF, 32'h0000_0001);
        queue_operands(32'h0000_0001, 32'h8000_0000);
        queue_operands(32'h1234_5678, 32'h0000_0003);
        queue_operands(32'hFFFF_FFFF, 32'hFFFF_FFFF);
        queue_operands(32'h7FFF_0000, 32'h0001_0000);

        for (int i = 0; i < RANDOM_OPERANDS; i++) begin
            r = $urandom_range(99);
            if (r < 45) begin
                a = $urandom;
                b = $urandom;
            end else if (r < 60) begin
                // small divisor drives the quotient out of range
                a = $urandom;
                b = with_random_sign($urandom_range(1, 32'h1_FFFF));
            end else if (r < 75) begin
                a = with_random_sign($urandom_range(0, 32'h3_FFFF));
                b = with_random_sign($urandom_range(1, 32'h3_FFFF));
            end else if (r < 82) begin
                a = $urandom;
                b = '0;
            end else if (r < 87) begin
                a = '0;
                b = $urandom;
            end else if (r < 94) begin
                // hug the overflow boundary: a ~ b * 2^(WW-1-FB)
                b = with_random_sign($urandom_range(1, 32'hFFFF));
                a = (b <<< (WW - 1 - FB)) + $signed(WW'($urandom_range(0, 6))) - 3;
            end else begin
                a = corners[$urandom_range(9)];
                b = corners[$urandom_range(9)];
            end
            queue_operands(a, b);
        end

        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;

        while (transfers_in != operands_total)
            @(posedge aclk);
        while (expected_quotients.size() != 0)
            @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        if (mismatches == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
